>>> sv/hlc_pkg.sv
`timescale 1ns / 1ps

package hlc_pkg;

	localparam int LOGICAL_BITS = 18;
	localparam int PHYS_W = 46;
	localparam int TS_W = 63;
	localparam int CNT_IN_W = 20;
	localparam int CNT_W = LOGICAL_BITS + 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 192;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_MARK  = 2'd1,
		OP_ERR   = 2'd2
	} op_t;

	typedef struct packed {
		op_t                     kind;
		logic [CNT_W-1:0]        count;
		logic [PHYS_W-1:0]       clock_ms;
		logic                    clock_ok;
		logic [TS_W-1:0]         mark_ts;
		logic [PHYS_W-1:0]       mark_phys;
		logic [LOGICAL_BITS-1:0] mark_logic;
	} entry_t;

	function automatic logic [PHYS_W-1:0] ts_phys(input logic [TS_W-1:0] ts);
		logic [63:0] shifted;
		shifted = 64'(ts) >> LOGICAL_BITS;
		return shifted[PHYS_W-1:0];
	endfunction

	function automatic logic [TS_W-1:0] make_ts(input logic [PHYS_W-1:0] phys,
			input logic [LOGICAL_BITS-1:0] logi);
		logic [63:0] packed_ts;
		packed_ts = (64'(phys) << LOGICAL_BITS) | 64'(logi);
		return packed_ts[TS_W-1:0];
	endfunction

endpackage

>>> sv/hlc_front.sv
`timescale 1ns / 1ps

module hlc_front (
	input  logic                          cmd,
	input  logic [hlc_pkg::CNT_IN_W-1:0]  batch_count,
	input  logic [hlc_pkg::PHYS_W-1:0]    clock_ms,
	input  logic                          clock_ok,
	input  logic [hlc_pkg::TS_W-1:0]      mark_ts,
	output hlc_pkg::entry_t               entry
);
	import hlc_pkg::*;

	logic [31:0] cnt32;

	always_comb begin
		cnt32 = 32'(batch_count);
		entry = '0;
		entry.clock_ms = clock_ms;
		entry.clock_ok = clock_ok;
		entry.mark_ts = mark_ts;
		entry.mark_phys = ts_phys(mark_ts);
		entry.mark_logic = mark_ts[LOGICAL_BITS-1:0];
		if (cnt32 > (32'd1 << LOGICAL_BITS)) begin
			entry.count = CNT_W'((32'd1 << LOGICAL_BITS) - 32'd1);
		end else begin
			entry.count = cnt32[CNT_W-1:0];
		end
		unique case (cmd)
			1'b0: entry.kind = (batch_count == '0) ? OP_ERR : OP_ALLOC;
			default: entry.kind = (mark_ts == '0) ? OP_ERR : OP_MARK;
		endcase
	end

endmodule

>>> sv/hlc_queue.sv
`timescale 1ns / 1ps

module hlc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hlc_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output hlc_pkg::entry_t head
);
	import hlc_pkg::*;

	entry_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < QCNT_W'(QDEPTH))
		else $error("queue pushed while full");

endmodule

>>> sv/hlc_back.sv
`timescale 1ns / 1ps

module hlc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  hlc_pkg::entry_t            head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_status,
	output logic [hlc_pkg::TS_W-1:0]   out_first,
	output logic [hlc_pkg::TS_W-1:0]   out_last,
	output logic [hlc_pkg::TS_W-1:0]   out_peak
);
	import hlc_pkg::*;

	logic [PHYS_W-1:0]       pc_q;
	logic [LOGICAL_BITS-1:0] lc_q;
	logic [TS_W-1:0]         rm_q;

	logic                    out_valid_q;
	logic                    out_status_q;
	logic [TS_W-1:0]         out_first_q;
	logic [TS_W-1:0]         out_last_q;
	logic [TS_W-1:0]         out_peak_q;

	logic [PHYS_W-1:0]       now;
	logic [PHYS_W-1:0]       wm_phys;
	logic [PHYS_W-1:0]       base;
	logic [PHYS_W-1:0]       next_base;
	logic [CNT_W-1:0]        sum;
	logic [CNT_W-1:0]        sum_m1;
	logic [PHYS_W-1:0]       pc_d;
	logic [LOGICAL_BITS-1:0] lc_d;
	logic [TS_W-1:0]         rm_d;
	logic                    status_d;
	logic [TS_W-1:0]         first_d;
	logic [TS_W-1:0]         last_d;

	assign pop = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		now = head.clock_ok ? head.clock_ms : pc_q;
		if (now < pc_q) now = pc_q;
		wm_phys = ts_phys(rm_q);
		base = ((rm_q != '0) && (wm_phys > now)) ? wm_phys : now;
		next_base = base + PHYS_W'(1);
		sum = CNT_W'(lc_q) + head.count;
		sum_m1 = sum - CNT_W'(1);

		pc_d = pc_q;
		lc_d = lc_q;
		rm_d = rm_q;
		status_d = 1'b0;
		first_d = '0;
		last_d = '0;
		unique case (head.kind)
			OP_ALLOC: begin
				first_d = make_ts(base, lc_q);
				last_d = make_ts(sum_m1[LOGICAL_BITS] ? next_base : base,
					sum_m1[LOGICAL_BITS-1:0]);
				pc_d = sum[LOGICAL_BITS] ? next_base : base;
				lc_d = sum[LOGICAL_BITS-1:0];
			end
			OP_MARK: begin
				if (head.mark_ts > rm_q) rm_d = head.mark_ts;
				if ((head.mark_phys > pc_q) ||
						((head.mark_phys == pc_q) && (head.mark_logic > lc_q))) begin
					pc_d = head.mark_phys;
					lc_d = head.mark_logic;
				end
			end
			default: begin
				status_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			lc_q <= '0;
			rm_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pc_q <= pc_d;
				lc_q <= lc_d;
				rm_q <= rm_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_status_q <= status_d;
			out_first_q <= first_d;
			out_last_q <= last_d;
			out_peak_q <= make_ts(pc_d, lc_d);
		end
	end

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_first = out_first_q;
	assign out_last = out_last_q;
	assign out_peak = out_peak_q;

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(pc_q) && $stable(lc_q) && $stable(rm_q))
		else $error("cursor state moved while the result was stalled");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.kind == OP_ERR |=> out_status_q && out_first_q == '0 &&
			out_last_q == '0 && $stable(pc_q) && $stable(rm_q))
		else $error("rejected item changed state or gave a range");

	a_mark_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rm_q >= $past(rm_q))
		else $error("recovery watermark moved backward");

endmodule

>>> sv/hlc_timestamp_allocator.sv
`timescale 1ns / 1ps

// Monotonic timestamp allocator built on a hybrid logical clock.
// Input items arrive on the s_axis channel: s_axis_tuser selects an allocate
// (0) or a recovered watermark insert (1). Each accepted item produces exactly
// one result item on the m_axis channel, carrying the status in m_axis_tuser
// and the first, last and peak timestamps in m_axis_tdata.
// An accepted item enters a two-entry queue after a decode stage. The execute
// stage reads the cursor registers, computes the range combinationally and
// writes the result register, so a result passes through a queue slot and
// the result register. One item per cycle is sustained while m_axis_tready
// is high; each cursor update feeds the next item via the cursor registers.
// When the receiver stalls, the result register holds, the execute stage stops
// and the queue fills; s_axis_tready drops only once the queue is full.
// Reset clears the physical and logical cursors, the watermark and the queue.
module hlc_timestamp_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// batch_count, clock_ms, clock_ok, mark_ts
	input  logic [hlc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// first_ts, last_ts, peak_ts
	output logic [hlc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// status
	output logic                           m_axis_tuser
);
	import hlc_pkg::*;

	localparam int CLK_LO = CNT_IN_W;
	localparam int OK_BIT = CLK_LO + PHYS_W;
	localparam int MARK_LO = OK_BIT + 1;

	entry_t          dec_entry;
	entry_t          head;
	logic            q_full;
	logic            head_valid;
	logic            pop;
	logic            push;
	logic [TS_W-1:0] out_first;
	logic [TS_W-1:0] out_last;
	logic [TS_W-1:0] out_peak;

	hlc_front u_front (
		.cmd         (s_axis_tuser),
		.batch_count (s_axis_tdata[CNT_IN_W-1:0]),
		.clock_ms    (s_axis_tdata[OK_BIT-1:CLK_LO]),
		.clock_ok    (s_axis_tdata[OK_BIT]),
		.mark_ts     (s_axis_tdata[MARK_LO+TS_W-1:MARK_LO]),
		.entry       (dec_entry)
	);

	assign s_axis_tready = !q_full;
	assign push = s_axis_tvalid && !q_full;

	hlc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (dec_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	hlc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_first  (out_first),
		.out_last   (out_last),
		.out_peak   (out_peak)
	);

	assign m_axis_tdata = {(M_TDATA_W - 3 * TS_W)'(0), out_peak, out_last, out_first};

endmodule

>>> tb/hlc_timestamp_allocator_tb.sv
`timescale 1ns / 1ps

module hlc_timestamp_allocator_tb;
	import hlc_pkg::*;

	localparam bit CMD_ALLOC = 1'b0;
	localparam bit CMD_MARK = 1'b1;
	localparam bit ST_OK = 1'b0;
	localparam bit ST_BAD_ARG = 1'b1;
	localparam bit [63:0] LMASK = (64'd1 << LOGICAL_BITS) - 64'd1;
	localparam bit [63:0] PMASK = (64'd1 << PHYS_W) - 64'd1;
	localparam bit [63:0] TMASK = (64'd1 << TS_W) - 64'd1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1750;
	localparam int WIDE_ITEMS = 150;

	typedef enum int {
		RX_OPEN,
		RX_SPARSE,
		RX_PATTERN,
		RX_COIN
	} rx_mode_t;

	typedef struct {
		bit                cmd;
		bit [CNT_IN_W-1:0] count;
		bit [PHYS_W-1:0]   clock_ms;
		bit                clock_ok;
		bit [TS_W-1:0]     mark_ts;
	} stamp_req_t;

	typedef struct {
		bit            status;
		bit [TS_W-1:0] first_ts;
		bit [TS_W-1:0] last_ts;
		bit [TS_W-1:0] peak_ts;
	} stamp_grant_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tuser;

	bit [PHYS_W-1:0]       cur_phys = '0;
	bit [LOGICAL_BITS-1:0] cur_logic = '0;
	bit [TS_W-1:0]         rec_mark = '0;
	stamp_grant_t          pending_grants[$];

	int       fail_count = 0;
	int       stall_count = 0;
	int       tx_burst_left = 0;
	bit       tx_gapless = 1'b0;
	bit       rx_hold_req = 1'b0;
	int       rx_hold_left = 0;
	int       rx_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;

	hlc_timestamp_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2 clk = ~clk;

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [TS_W-1:0] pack_ts(input bit [63:0] phys, input bit [63:0] logi);
		bit [63:0] t;
		t = ((phys & PMASK) << LOGICAL_BITS) | (logi & LMASK);
		return t[TS_W-1:0];
	endfunction

	function automatic stamp_grant_t grant_stamps(input stamp_req_t r);
		stamp_grant_t g;
		bit [63:0] cnt, base, start, slots, rem, nxt, mp, ml;
		g.status = ST_OK;
		g.first_ts = '0;
		g.last_ts = '0;
		if (r.cmd == CMD_ALLOC) begin
			if (r.count == '0) begin
				g.status = ST_BAD_ARG;
			end else begin
				cnt = 64'(r.count);
				if (cnt > LMASK + 64'd1)
					cnt = LMASK;
				base = r.clock_ok ? 64'(r.clock_ms) : 64'(cur_phys);
				if (base < 64'(cur_phys))
					base = 64'(cur_phys);
				mp = (64'(rec_mark) >> LOGICAL_BITS) & PMASK;
				if (rec_mark != '0 && mp > base)
					base = mp;
				start = 64'(cur_logic);
				g.first_ts = pack_ts(base, start);
				slots = LMASK + 64'd1 - start;
				if (cnt < slots) begin
					g.last_ts = pack_ts(base, start + cnt - 64'd1);
					start = start + cnt;
				end else begin
					rem = cnt - slots;
					nxt = (base + 64'd1) & PMASK;
					g.last_ts = (rem == 64'd0) ? pack_ts(base, LMASK) : pack_ts(nxt, rem - 64'd1);
					start = rem;
					base = nxt;
				end
				cur_phys = base[PHYS_W-1:0];
				cur_logic = start[LOGICAL_BITS-1:0];
			end
		end else begin
			if (r.mark_ts == '0) begin
				g.status = ST_BAD_ARG;
			end else begin
				mp = (64'(r.mark_ts) >> LOGICAL_BITS) & PMASK;
				ml = 64'(r.mark_ts) & LMASK;
				if (r.mark_ts > rec_mark)
					rec_mark = r.mark_ts;
				if (mp > 64'(cur_phys) || (mp == 64'(cur_phys) && ml > 64'(cur_logic))) begin
					cur_phys = mp[PHYS_W-1:0];
					cur_logic = ml[LOGICAL_BITS-1:0];
				end
			end
		end
		g.peak_ts = pack_ts(64'(cur_phys), 64'(cur_logic));
		return g;
	endfunction

	function automatic stamp_req_t alloc_req(input bit [63:0] count, input bit [63:0] clock,
			input bit ok);
		stamp_req_t r;
		bit [63:0] filler;
		filler = rand64();
		r.cmd = CMD_ALLOC;
		r.count = count[CNT_IN_W-1:0];
		r.clock_ms = clock[PHYS_W-1:0];
		r.clock_ok = ok;
		r.mark_ts = filler[TS_W-1:0];
		return r;
	endfunction

	function automatic stamp_req_t mark_req(input bit [63:0] ts);
		stamp_req_t r;
		bit [63:0] filler;
		filler = rand64();
		r.cmd = CMD_MARK;
		r.count = filler[CNT_IN_W-1:0];
		r.clock_ok = filler[CNT_IN_W];
		filler = rand64();
		r.clock_ms = filler[PHYS_W-1:0];
		r.mark_ts = ts[TS_W-1:0];
		return r;
	endfunction

	task automatic send_item(input stamp_req_t r);
		bit [S_TDATA_W-1:0] bus;
		int gap;
		bus = '0;
		bus[CNT_IN_W+PHYS_W+TS_W:0] = {r.mark_ts, r.clock_ok, r.clock_ms, r.count};
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 40);
			gap = (tx_gapless || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		tx_burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= bus;
		s_axis_tuser <= r.cmd;
		do @(posedge clk); while (!s_axis_tready);
		pending_grants.push_back(grant_stamps(r));
	endtask

	task automatic test_errors();
		send_item(alloc_req(64'd0, PMASK, 1'b1));
		send_item(mark_req(64'd0));
	endtask

	task automatic test_batch_sizes();
		send_item(alloc_req(64'd1, 64'd5, 1'b1));
		send_item(alloc_req(LMASK + 64'd1, 64'd5, 1'b1));
		send_item(alloc_req(LMASK + 64'd1 - 64'(cur_logic), 64'd0, 1'b1));
		send_item(alloc_req(LMASK + 64'd2, 64'd0, 1'b1));
		send_item(alloc_req(64'hF_FFFF, 64'd0, 1'b1));
		send_item(alloc_req(64'd3, 64'd0, 1'b1));
	endtask

	task automatic test_clock_source();
		send_item(alloc_req(64'd1, PMASK, 1'b0));
		send_item(alloc_req(64'd1, 64'd0, 1'b1));
		send_item(alloc_req(64'd2, 64'(cur_phys) + 64'd100, 1'b1));
		// A full batch at the top of the clock range wraps the physical cursor.
		send_item(alloc_req(LMASK + 64'd1, PMASK, 1'b1));
		send_item(alloc_req(64'd4, 64'd7, 1'b1));
	endtask

	task automatic test_watermark();
		send_item(mark_req((64'd300 << LOGICAL_BITS) | 64'd7));
		send_item(alloc_req(64'd1, 64'd0, 1'b1));
		send_item(mark_req((64'd50 << LOGICAL_BITS) | 64'd9));
		send_item(mark_req(64'(pack_ts(64'(cur_phys), 64'(cur_logic) + 64'd5))));
		send_item(mark_req(64'(pack_ts(64'(cur_phys), 64'(cur_logic)))));
		send_item(alloc_req(64'd2, 64'd0, 1'b0));
		send_item(alloc_req(64'd1, 64'd1000, 1'b1));
		send_item(mark_req((64'd500 << LOGICAL_BITS) | 64'd1));
	endtask

	task automatic test_backpressure();
		rx_hold_req = 1'b1;
		tx_gapless = 1'b1;
		tx_burst_left = 0;
		repeat (24)
			send_item(alloc_req(64'($urandom_range(1, 64)), 64'(cur_phys) + 64'd1, 1'b1));
		tx_gapless = 1'b0;
	endtask

	task automatic test_random_traffic(input int n);
		stamp_req_t r;
		bit [63:0] wall, peak, delta, v;
		int pick;
		wall = 64'(cur_phys) + 64'd1;
		for (int i = 0; i < n; i++) begin
			wall = (wall + 64'($urandom_range(0, 2))) & PMASK;
			if (wall < 64'(cur_phys) && $urandom_range(0, 3) == 0)
				wall = 64'(cur_phys) + 64'($urandom_range(0, 3));
			if ($urandom_range(0, 99) < 82) begin
				r = alloc_req(64'd1, wall, 1'b1);
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					delta = 64'($urandom_range(1, 50));
					v = (wall > delta) ? wall - delta : 64'd0;
					r.clock_ms = v[PHYS_W-1:0];
				end else if (pick < 30) begin
					v = rand64();
					r.clock_ok = 1'b0;
					r.clock_ms = v[PHYS_W-1:0];
				end
				pick = $urandom_range(0, 99);
				if (pick < 45)
					v = 64'($urandom_range(1, 16));
				else if (pick < 65)
					v = 64'($urandom_range(1, 4096));
				else if (pick < 75)
					v = LMASK + 64'd1 - 64'(cur_logic) + 64'($urandom_range(0, 2)) - 64'd1;
				else if (pick < 82)
					v = LMASK + 64'($urandom_range(0, 2));
				else if (pick < 92)
					v = rand64();
				else if (pick < 95)
					v = 64'd0;
				else
					v = 64'($urandom_range(1, 32'(LMASK)));
				r.count = v[CNT_IN_W-1:0];
			end else begin
				r = mark_req(64'd1);
				peak = 64'(pack_ts(64'(cur_phys), 64'(cur_logic)));
				delta = 64'($urandom_range(1, 1 << 20));
				pick = $urandom_range(0, 99);
				if (pick < 35)
					v = peak + delta;
				else if (pick < 60)
					v = (peak > delta) ? peak - delta : 64'd1;
				else if (pick < 75)
					v = peak + 64'($urandom_range(0, 3));
				else if (pick < 80)
					v = 64'd0;
				else
					v = ((wall + 64'($urandom_range(0, 8))) << LOGICAL_BITS)
						| 64'($urandom_range(0, 32'(LMASK)));
				r.mark_ts = v[TS_W-1:0];
			end
			send_item(r);
		end
	endtask

	task automatic test_wide_random(input int n);
		stamp_req_t r;
		bit [63:0] v;
		for (int i = 0; i < n; i++) begin
			v = rand64();
			r.cmd = v[0];
			r.clock_ok = v[1];
			v = rand64();
			r.count = v[CNT_IN_W-1:0];
			v = rand64();
			r.clock_ms = v[PHYS_W-1:0];
			v = rand64();
			r.mark_ts = v[TS_W-1:0];
			send_item(r);
		end
	endtask

	task automatic test_watermark_ceiling();
		send_item(mark_req(TMASK));
		send_item(alloc_req(LMASK + 64'd1, 64'd0, 1'b1));
		send_item(mark_req(TMASK));
		send_item(alloc_req(64'd1, PMASK, 1'b1));
		send_item(alloc_req(LMASK + 64'd1, PMASK, 1'b1));
		send_item(alloc_req(64'd1, 64'd0, 1'b1));
	endtask

	task automatic compare_field(input string name, input bit [63:0] want, input bit [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		stamp_grant_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_grants.size() == 0) begin
				$error("result item with nothing pending: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_grants.pop_front();
				compare_field("status", 64'(want.status), 64'(m_axis_tuser));
				compare_field("first_ts", 64'(want.first_ts), 64'(m_axis_tdata[TS_W-1:0]));
				compare_field("last_ts", 64'(want.last_ts), 64'(m_axis_tdata[2*TS_W-1:TS_W]));
				compare_field("peak_ts", 64'(want.peak_ts), 64'(m_axis_tdata[3*TS_W-1:2*TS_W]));
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			rx_tick++;
			if (rx_tick % 150 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN: m_axis_tready <= 1'b1;
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: m_axis_tready <= (rx_tick % 7 < 4);
				default: m_axis_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_errors();
		test_batch_sizes();
		test_clock_source();
		test_watermark();
		test_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		test_wide_random(WIDE_ITEMS);
		test_watermark_ceiling();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/hlc_pkg.sv
sv/hlc_front.sv
sv/hlc_queue.sv
sv/hlc_back.sv
sv/hlc_timestamp_allocator.sv
tb/hlc_timestamp_allocator_tb.sv
